[hdl/ctrm_pkg.sv]
// Shared types and codes for the cell-to-row matcher.
`timescale 1ns / 1ps

package ctrm_pkg;

  // Width of the cell width and height fields; also the remainder pipeline depth.
  localparam int DIM_BITS = 24;
  // Width of the reported row index.
  localparam int INDEX_BITS = 10;

  // Action codes of an input item.
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // Result status codes.
  localparam logic [2:0] STAT_MATCH   = 3'd0;
  localparam logic [2:0] STAT_NOMATCH = 3'd1;
  localparam logic [2:0] STAT_LOADED  = 3'd2;
  localparam logic [2:0] STAT_FULL    = 3'd3;
  localparam logic [2:0] STAT_CLEARED = 3'd4;

  // Control state of the matcher.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } ctrm_state_t;

  // Control entering the remainder pipeline.
  typedef struct packed {
    logic valid;
    logic geom_ok;
  } ctrm_pipe_in_t;

  // Status leaving the remainder pipeline.
  typedef struct packed {
    logic hit;
    logic busy;
  } ctrm_pipe_out_t;

endpackage

[hdl/ctrm_rem_pipe.sv]
// Pipelined restoring remainder of the cell height by a row extent, one bit per stage.
`timescale 1ns / 1ps

module ctrm_rem_pipe #(
  parameter int IDX_BITS = 10,
  parameter int MAG_BITS = 33
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          flush,
  input  logic [ctrm_pkg::DIM_BITS-1:0] dividend,
  input  ctrm_pkg::ctrm_pipe_in_t       in_ctl,
  input  logic [IDX_BITS-1:0]           in_idx,
  input  logic [MAG_BITS-1:0]           in_mag,
  output ctrm_pkg::ctrm_pipe_out_t      out_ctl,
  output logic [IDX_BITS-1:0]           out_idx
);

  localparam int N  = ctrm_pkg::DIM_BITS;
  localparam int TW = ((MAG_BITS > N) ? MAG_BITS : N) + 1;

  logic [N-1:0]        vld;
  logic                ok       [N];
  logic [IDX_BITS-1:0] idx      [N];
  logic [MAG_BITS-1:0] mag      [N];
  logic [N-1:0]        rem      [N];
  logic [N-1:0]        rem_next [N];
  logic [TW-1:0]       trial    [N];
  logic [TW-1:0]       mext     [N];

  // One shift-compare-subtract per stage, each on its own stage register
  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        trial[k] = TW'({{(N){1'b0}}, dividend[N-1]});
        mext[k]  = TW'(in_mag);
      end else begin
        trial[k] = TW'({rem[k-1], dividend[N-1-k]});
        mext[k]  = TW'(mag[k-1]);
      end
      if (trial[k] >= mext[k]) begin
        rem_next[k] = N'(trial[k] - mext[k]);
      end else begin
        rem_next[k] = N'(trial[k]);
      end
    end
  end

  // Stage valid bits; a flush drops everything in flight
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      vld <= '0;
    end else begin
      vld <= {vld[N-2:0], in_ctl.valid};
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        ok[k]  <= in_ctl.geom_ok;
        idx[k] <= in_idx;
        mag[k] <= in_mag;
      end else begin
        ok[k]  <= ok[k-1];
        idx[k] <= idx[k-1];
        mag[k] <= mag[k-1];
      end
      rem[k] <= rem_next[k];
    end
  end

  // A hit needs the geometry test passed and a zero remainder
  assign out_ctl.hit  = vld[N-1] && ok[N-1] && (rem[N-1] == '0);
  assign out_ctl.busy = |vld;
  assign out_idx      = idx[N-1];

endmodule

[hdl/cell_to_row_matcher_core.sv]
// Top level of the cell-to-row matcher: row table, control and result register.
`timescale 1ns / 1ps

// Keeps up to MAX_ROWS row rectangles in one synchronous memory and answers
// one result per input item. Load, clear and unused actions pass from the
// transfer to the result stage and then to the output register. A query
// reads one row per cycle from the memory port and runs each row through a
// geometry stage and a 24-stage pipelined remainder of the cell height by
// the row extent; the first row that fits wins and the rest in flight are
// dropped. A query with no match scans every loaded row, and one on an
// empty table goes to the result stage without reading a row. The next
// item is taken once the current result has moved from the result stage
// into the output register, while it may still be waiting on the output.
// Row storage needs no clearing after reset.
module cell_to_row_matcher_core #(
  parameter int MAX_ROWS   = 1024,
  parameter int COORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          action,
  input  logic signed [COORD_BITS-1:0]        rect_left,
  input  logic signed [COORD_BITS-1:0]        rect_bottom,
  input  logic signed [COORD_BITS-1:0]        row_right,
  input  logic signed [COORD_BITS-1:0]        row_top,
  input  logic [ctrm_pkg::DIM_BITS-1:0]       cell_width,
  input  logic [ctrm_pkg::DIM_BITS-1:0]       cell_height,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          status,
  output logic [ctrm_pkg::INDEX_BITS-1:0]     row_index
);

  localparam int CB = COORD_BITS;
  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int EB = ((CB > ctrm_pkg::DIM_BITS) ? CB : ctrm_pkg::DIM_BITS) + 2;
  localparam int MB = CB + 1;
  localparam int IW = (AW > ctrm_pkg::INDEX_BITS) ? AW : ctrm_pkg::INDEX_BITS;

  ctrm_pkg::ctrm_state_t state, state_next;

  logic                          vertical_rows;
  logic [CW-1:0]                 row_count;
  logic [CW-1:0]                 iss;
  logic                          in_xfer;
  logic                          issue;
  logic                          flush;
  logic                          scan_busy;
  logic                          out_load;

  // Query operands, arranged along and across the row axis
  logic signed [CB-1:0]          q_p;
  logic signed [CB-1:0]          q_q;
  logic signed [EB-1:0]          q_e;
  logic                          q_nz;
  logic [ctrm_pkg::DIM_BITS-1:0] q_h;
  logic signed [CB-1:0]          acc_p;

  // Pending result
  logic [2:0]                    res_status;
  logic [AW-1:0]                 res_idx;
  logic [IW-1:0]                 res_idx_w;

  // Row memory and read stage
  logic [4*CB-1:0]               row_mem [MAX_ROWS];
  logic [4*CB-1:0]               rd_data;
  logic                          rd_vld;
  logic [AW-1:0]                 rd_idx;

  // Geometry stage
  logic signed [CB-1:0]          r_l, r_b, r_r, r_t;
  logic signed [CB-1:0]          lo, hi, base, far;
  logic                          geom_ok;
  logic [MB-1:0]                 geom_mag;
  logic                          g_vld;
  logic                          g_ok;
  logic [AW-1:0]                 g_idx;
  logic [MB-1:0]                 g_mag;

  ctrm_pkg::ctrm_pipe_in_t       g_ctl;
  ctrm_pkg::ctrm_pipe_out_t      pipe_out;
  logic [AW-1:0]                 pipe_idx;

  assign in_ready = (state == ctrm_pkg::S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state == ctrm_pkg::S_RESULT) && (!out_valid || out_ready);
  assign scan_busy = rd_vld || g_vld || pipe_out.busy;

  // Orientation register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertical_rows <= 1'b0;
    end else if (cfg_wr_en) begin
      vertical_rows <= cfg_wr_data;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctrm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    flush      = 1'b0;
    unique case (state)
      ctrm_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_next = (action == ctrm_pkg::ACT_QUERY) ? ctrm_pkg::S_SCAN : ctrm_pkg::S_RESULT;
        end
      end
      ctrm_pkg::S_SCAN: begin
        if (pipe_out.hit) begin
          flush      = 1'b1;
          state_next = ctrm_pkg::S_RESULT;
        end else if (iss < row_count) begin
          issue = 1'b1;
        end else if (!scan_busy) begin
          state_next = ctrm_pkg::S_RESULT;
        end
      end
      ctrm_pkg::S_RESULT: begin
        if (out_load) begin
          state_next = ctrm_pkg::S_IDLE;
        end
      end
      default: state_next = ctrm_pkg::S_IDLE;
    endcase
  end

  // Row count and scan pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      iss       <= '0;
    end else begin
      if (in_xfer) begin
        iss <= '0;
        if (action == ctrm_pkg::ACT_LOAD && row_count < CW'(MAX_ROWS)) begin
          row_count <= row_count + CW'(1);
        end else if (action == ctrm_pkg::ACT_CLEAR) begin
          row_count <= '0;
        end
      end else if (issue) begin
        iss <= iss + CW'(1);
      end
    end
  end

  // Query operand capture; the along-row axis is y for vertical rows
  assign acc_p = vertical_rows ? rect_bottom : rect_left;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      q_p  <= acc_p;
      q_q  <= vertical_rows ? rect_left : rect_bottom;
      q_e  <= EB'(acc_p) + EB'($signed({1'b0, cell_width}));
      q_nz <= (cell_width != '0) && (cell_height != '0);
      q_h  <= cell_height;
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_idx <= '0;
      unique case (action)
        ctrm_pkg::ACT_LOAD: begin
          if (row_count < CW'(MAX_ROWS)) begin
            res_status <= ctrm_pkg::STAT_LOADED;
            res_idx    <= row_count[AW-1:0];
          end else begin
            res_status <= ctrm_pkg::STAT_FULL;
          end
        end
        ctrm_pkg::ACT_CLEAR: res_status <= ctrm_pkg::STAT_CLEARED;
        default:             res_status <= ctrm_pkg::STAT_NOMATCH;
      endcase
    end else if (state == ctrm_pkg::S_SCAN && pipe_out.hit) begin
      res_status <= ctrm_pkg::STAT_MATCH;
      res_idx    <= pipe_idx;
    end
  end

  // Row memory: write on load, registered read during a scan
  always_ff @(posedge clk) begin
    if (in_xfer && action == ctrm_pkg::ACT_LOAD && row_count < CW'(MAX_ROWS)) begin
      row_mem[row_count[AW-1:0]] <= {row_top, row_right, rect_bottom, rect_left};
    end
    if (issue) begin
      rd_data <= row_mem[iss[AW-1:0]];
    end
  end

  // Read and geometry stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      g_vld  <= 1'b0;
    end else begin
      rd_vld <= issue;
      g_vld  <= rd_vld && !flush;
    end
  end

  // Geometry test on the row just read
  assign r_l  = rd_data[CB-1:0];
  assign r_b  = rd_data[2*CB-1:CB];
  assign r_r  = rd_data[3*CB-1:2*CB];
  assign r_t  = rd_data[4*CB-1:3*CB];
  assign lo   = vertical_rows ? r_b : r_l;
  assign hi   = vertical_rows ? r_t : r_r;
  assign base = vertical_rows ? r_l : r_b;
  assign far  = vertical_rows ? r_r : r_t;

  assign geom_ok = (lo <= q_p) && (q_p < hi) && (q_e <= EB'(hi)) &&
                   (q_q == base) && q_nz && (far != base);

  // Magnitude of the row extent across the row
  always_comb begin
    if (far >= base) begin
      geom_mag = MB'(far) - MB'(base);
    end else begin
      geom_mag = MB'(base) - MB'(far);
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= iss[AW-1:0];
    g_ok   <= geom_ok;
    g_idx  <= rd_idx;
    g_mag  <= geom_mag;
  end

  assign g_ctl.valid   = g_vld;
  assign g_ctl.geom_ok = g_ok;

  ctrm_rem_pipe #(
    .IDX_BITS (AW),
    .MAG_BITS (MB)
  ) u_rem_pipe (
    .clk      (clk),
    .rst      (rst),
    .flush    (flush),
    .dividend (q_h),
    .in_ctl   (g_ctl),
    .in_idx   (g_idx),
    .in_mag   (g_mag),
    .out_ctl  (pipe_out),
    .out_idx  (pipe_idx)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res_idx_w = IW'(res_idx);

  always_ff @(posedge clk) begin
    if (out_load) begin
      status    <= res_status;
      row_index <= res_idx_w[ctrm_pkg::INDEX_BITS-1:0];
    end
  end

  // Checks
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    row_count <= CW'(MAX_ROWS))
    else $error("row count above table depth");

  a_hit_in_scan: assert property (@(posedge clk) disable iff (rst)
    pipe_out.hit |-> state == ctrm_pkg::S_SCAN)
    else $error("remainder pipeline hit outside a scan");

  a_match_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == ctrm_pkg::S_RESULT && res_status == ctrm_pkg::STAT_MATCH) |->
      (CW'(res_idx) < row_count))
    else $error("matched row beyond loaded rows");

  a_load_counts: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && action == ctrm_pkg::ACT_LOAD && row_count < CW'(MAX_ROWS)) |=>
      (row_count == $past(row_count) + CW'(1)))
    else $error("load did not advance row count");

endmodule

[bench/tb_cell_to_row_matcher_core.sv]
// Self-checking testbench for the cell-to-row matcher: row-table predictor and stimulus.
`timescale 1ns / 1ps

module tb_cell_to_row_matcher_core;

  localparam int TABLE_ROWS = 1024;
  localparam int COORD_W = 32;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam longint DIM_MAX = 64'sd16777215;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam bit MODE_HORIZ = 1'b0;
  localparam bit MODE_VERT = 1'b1;
  localparam int RANDOM_ITEMS = 260;
  localparam int SETTLE_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 2000000;

  // Predicts status and row index of every transfer into the matcher.
  class row_match_board;
    longint left_edge[TABLE_ROWS];
    longint bottom_edge[TABLE_ROWS];
    longint right_edge[TABLE_ROWS];
    longint top_edge[TABLE_ROWS];
    int row_count;
    bit vertical;
    logic [2:0] exp_status[$];
    logic [ctrm_pkg::INDEX_BITS-1:0] exp_index[$];
    int errors;

    function int pending();
      return exp_status.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    // Row containment test for the current orientation.
    function bit row_fits(int i, longint x, longint y, longint w, longint h);
      longint bx, by, tx, ty, ext;
      bx = left_edge[i];
      by = bottom_edge[i];
      tx = right_edge[i];
      ty = top_edge[i];
      if (vertical == MODE_HORIZ) begin
        ext = ty - by;
        if (ext < 0) ext = -ext;
        return x >= bx && x < tx && x + w > x && x + w <= tx &&
               y == by && y + h > by && ext != 0 && (h % ext) == 0;
      end
      ext = tx - bx;
      if (ext < 0) ext = -ext;
      return x == bx && x + h > bx && ext != 0 && (h % ext) == 0 &&
             y >= by && y < ty && y + w > y && y + w <= ty;
    endfunction

    function void note_item(logic [1:0] act, logic [COORD_W-1:0] l,
                            logic [COORD_W-1:0] b, logic [COORD_W-1:0] r,
                            logic [COORD_W-1:0] t,
                            logic [ctrm_pkg::DIM_BITS-1:0] w,
                            logic [ctrm_pkg::DIM_BITS-1:0] h);
      logic [2:0] st;
      logic [ctrm_pkg::INDEX_BITS-1:0] idx;
      st = ctrm_pkg::STAT_NOMATCH;
      idx = '0;
      case (act)
        ctrm_pkg::ACT_LOAD: begin
          if (row_count < TABLE_ROWS) begin
            left_edge[row_count] = longint'($signed(l));
            bottom_edge[row_count] = longint'($signed(b));
            right_edge[row_count] = longint'($signed(r));
            top_edge[row_count] = longint'($signed(t));
            idx = row_count[ctrm_pkg::INDEX_BITS-1:0];
            row_count++;
            st = ctrm_pkg::STAT_LOADED;
          end else begin
            st = ctrm_pkg::STAT_FULL;
          end
        end
        ctrm_pkg::ACT_CLEAR: begin
          row_count = 0;
          st = ctrm_pkg::STAT_CLEARED;
        end
        ctrm_pkg::ACT_QUERY: begin
          // first row in load order wins
          for (int i = 0; i < row_count; i++) begin
            if (row_fits(i, longint'($signed(l)), longint'($signed(b)),
                         longint'(w), longint'(h))) begin
              st = ctrm_pkg::STAT_MATCH;
              idx = i[ctrm_pkg::INDEX_BITS-1:0];
              break;
            end
          end
        end
        default: ;
      endcase
      exp_status = {exp_status, st};
      exp_index = {exp_index, idx};
    endfunction

    function void check_result(logic [2:0] st, logic [ctrm_pkg::INDEX_BITS-1:0] idx);
      logic [2:0] es;
      logic [ctrm_pkg::INDEX_BITS-1:0] ei;
      if (exp_status.size() == 0) begin
        flag($sformatf("unexpected result: status %0d index %0d", st, idx));
        return;
      end
      es = exp_status.pop_front();
      ei = exp_index.pop_front();
      if (st !== es || idx !== ei)
        flag($sformatf("mismatch: expected status %0d index %0d, got status %0d index %0d",
                       es, ei, st, idx));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;
  logic in_valid;
  logic in_ready;
  logic [1:0] action;
  logic signed [COORD_W-1:0] rect_left;
  logic signed [COORD_W-1:0] rect_bottom;
  logic signed [COORD_W-1:0] row_right;
  logic signed [COORD_W-1:0] row_top;
  logic [ctrm_pkg::DIM_BITS-1:0] cell_width;
  logic [ctrm_pkg::DIM_BITS-1:0] cell_height;
  logic out_valid;
  logic out_ready;
  logic [2:0] status;
  logic [ctrm_pkg::INDEX_BITS-1:0] row_index;

  row_match_board sb = new;
  bit quiet_phase;
  int items_sent;
  longint cycle_count;

  cell_to_row_matcher_core #(
    .MAX_ROWS(TABLE_ROWS),
    .COORD_BITS(COORD_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .rect_left(rect_left),
    .rect_bottom(rect_bottom),
    .row_right(row_right),
    .row_top(row_top),
    .cell_width(cell_width),
    .cell_height(cell_height),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .row_index(row_index)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cell_to_row_matcher_core test failed");
      $finish;
    end
  end

  // transfer monitor: results are checked before the new item is predicted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(status, row_index);
      if (in_valid && in_ready)
        sb.note_item(action, rect_left, rect_bottom, row_right, row_top,
                     cell_width, cell_height);
    end
  end

  // result side: random stall before each transfer
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  function automatic longint rand_below(longint span);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return longint'(raw >> 1) % span;
  endfunction

  function automatic longint rand_coord();
    return longint'($signed($urandom));
  endfunction

  // start point such that start and start + span are both valid coordinates
  function automatic longint place(longint span);
    longint lo, hi;
    lo = COORD_MIN;
    hi = COORD_MAX;
    if (span < 0) lo = COORD_MIN - span;
    else hi = COORD_MAX - span;
    return lo + rand_below(hi - lo + 1);
  endfunction

  // one input transfer, after a random gap
  task automatic send_item(input logic [1:0] act, input longint l, input longint b,
                           input longint r, input longint t, input longint w,
                           input longint h);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    action <= act;
    rect_left <= l[COORD_W-1:0];
    rect_bottom <= b[COORD_W-1:0];
    row_right <= r[COORD_W-1:0];
    row_top <= t[COORD_W-1:0];
    cell_width <= w[ctrm_pkg::DIM_BITS-1:0];
    cell_height <= h[ctrm_pkg::DIM_BITS-1:0];
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    items_sent++;
  endtask

  task automatic load_row(input longint l, input longint b, input longint r, input longint t);
    send_item(ctrm_pkg::ACT_LOAD, l, b, r, t, 0, 0);
  endtask

  task automatic query_cell(input longint x, input longint y, input longint w, input longint h);
    send_item(ctrm_pkg::ACT_QUERY, x, y, 0, 0, w, h);
  endtask

  // wait until every result is in and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input bit v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.vertical = v;
  endtask

  task automatic send_noise_query();
    send_item(ctrm_pkg::ACT_QUERY, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              $urandom_range(0, DIM_MAX), $urandom_range(0, DIM_MAX));
  endtask

  // row with a small or odd extent, placed anywhere in the coordinate range
  task automatic load_random_row();
    longint len, ext, a, b;
    len = 1 + rand_below(($urandom_range(0, 3) == 0) ? 64'sd4294967295 : 64'sd5000);
    if ($urandom_range(0, 9) == 0) len = -len;
    case ($urandom_range(0, 9))
      0: ext = 0;
      1, 2: ext = -(1 + rand_below(64));
      3: ext = 1 + rand_below(64'sd1048576);
      default: ext = 1 + rand_below(64);
    endcase
    a = place(len);
    b = place(ext);
    if (sb.vertical == MODE_HORIZ) load_row(a, b, a + len, b + ext);
    else load_row(b, a, b + ext, a + len);
  endtask

  // query built to fit a stored row, sometimes just missing it
  task automatic query_fitting();
    int r;
    longint lo, span, ext, pos, w, h, kmax, fixed, room;
    if (sb.row_count == 0) begin
      send_noise_query();
      return;
    end
    r = $urandom_range(0, sb.row_count - 1);
    if (sb.vertical == MODE_HORIZ) begin
      lo = sb.left_edge[r];
      span = sb.right_edge[r] - lo;
      ext = sb.top_edge[r] - sb.bottom_edge[r];
      fixed = sb.bottom_edge[r];
    end else begin
      lo = sb.bottom_edge[r];
      span = sb.top_edge[r] - lo;
      ext = sb.right_edge[r] - sb.left_edge[r];
      fixed = sb.left_edge[r];
    end
    if (ext < 0) ext = -ext;
    if (span <= 0 || ext == 0 || ext > DIM_MAX) begin
      send_noise_query();
      return;
    end
    pos = lo + rand_below(span);
    room = lo + span - pos;
    if (room > DIM_MAX) room = DIM_MAX;
    w = 1 + rand_below(room);
    kmax = DIM_MAX / ext;
    if ($urandom_range(0, 1) == 0 && kmax > 4) kmax = 4;
    h = ext * (1 + rand_below(kmax));
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 2))
        0: if (ext > 1) h = h - 1;
        1: if (room < DIM_MAX) w = room + 1;
        default: fixed = fixed + 1;
      endcase
    end
    if (sb.vertical == MODE_HORIZ) query_cell(pos, fixed, w, h);
    else query_cell(fixed, pos, w, h);
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 9))
      0: send_item(ctrm_pkg::ACT_CLEAR, rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), $urandom_range(0, DIM_MAX), $urandom_range(0, DIM_MAX));
      1: send_item(ACT_UNUSED, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   $urandom_range(0, DIM_MAX), $urandom_range(0, DIM_MAX));
      2, 3, 4: send_item(ctrm_pkg::ACT_LOAD, rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), $urandom_range(0, DIM_MAX),
                         $urandom_range(0, DIM_MAX));
      default: send_noise_query();
    endcase
  endtask

  // clear most of the time, load a few rows, then mostly fitting queries
  task automatic run_random_phase();
    int n_rows, n_q;
    quiet_phase = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 3) != 0) write_mode(1'($urandom_range(0, 1)));
    if ($urandom_range(0, 4) != 0) send_item(ctrm_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0);
    n_rows = $urandom_range(1, 8);
    repeat (n_rows) load_random_row();
    n_q = $urandom_range(4, 14);
    repeat (n_q) begin
      if ($urandom_range(0, 9) < 7) query_fitting();
      else send_noise();
    end
    drain();
  endtask

  initial begin
    int start;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid = 1'b0;
    action = ctrm_pkg::ACT_LOAD;
    rect_left = '0;
    rect_bottom = '0;
    row_right = '0;
    row_top = '0;
    cell_width = '0;
    cell_height = '0;
    quiet_phase = 1'b0;
    items_sent = 0;
    cycle_count = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // horizontal rows: empty table, unused code, extremes, zero and negative height
    write_mode(MODE_HORIZ);
    query_cell(10, 100, 20, 30);
    send_item(ACT_UNUSED, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, DIM_MAX, DIM_MAX);
    load_row(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    load_row(0, 100, 1000, 100);
    load_row(0, 100, 1000, 90);
    query_cell(10, 100, 20, 30);
    query_cell(10, 100, 0, 30);
    query_cell(999, 100, DIM_MAX, 10);
    query_cell(10, 100, 20, 0);
    query_cell(COORD_MAX, COORD_MAX, DIM_MAX, DIM_MAX);
    send_item(ctrm_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0);
    query_cell(10, 100, 20, 30);
    drain();

    // vertical rows: negative width, zero width, top edge
    write_mode(MODE_VERT);
    load_row(50, 0, 40, 1000);
    load_row(60, 0, 60, 1000);
    query_cell(50, 5, 100, 30);
    query_cell(60, 5, 10, 10);
    query_cell(50, 999, 1, 10);
    query_cell(50, 1000, 1, 10);
    drain();

    // row at the bottom corner of the coordinate range
    write_mode(MODE_HORIZ);
    send_item(ctrm_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0);
    load_row(COORD_MIN, COORD_MIN, COORD_MIN + 100, COORD_MIN + 7);
    query_cell(COORD_MIN, COORD_MIN, 100, 21);
    query_cell(COORD_MIN, COORD_MIN, 101, 21);
    send_item(ctrm_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0);
    drain();

    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) run_random_phase();
    quiet_phase = 1'b0;

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("cell_to_row_matcher_core test passed");
    end else begin
      $display("cell_to_row_matcher_core test failed");
    end
    $finish;
  end

endmodule
